/* hw/rtl/lcdnf_pkg.sv */
// Shared types, codes and byte tables for the LCD number display formatter.
// No dependencies; used by lcdnf_bcd and lcd_number_display_formatter.
package lcdnf_pkg;

  // Function codes of a request
  localparam logic [2:0] FUNC_UDEC = 3'd0;
  localparam logic [2:0] FUNC_SDEC = 3'd1;
  localparam logic [2:0] FUNC_HEX  = 3'd2;
  localparam logic [2:0] FUNC_CHAR = 3'd3;
  localparam logic [2:0] FUNC_INIT = 3'd4;

  // Cursor line codes
  localparam logic [1:0] LINE_TOP = 2'd1;
  localparam logic [1:0] LINE_BOT = 2'd2;

  // Decimal digit limits
  localparam logic [3:0] MAX_DIGITS = 4'd10;
  localparam int BIN_W      = 17;                 // magnitude width, magnitudes up to 65535
  localparam int BCD_DIGITS = 5;                  // enough for 99999
  localparam int POS_W      = $clog2(BCD_DIGITS);
  localparam int ITER_W     = $clog2(BIN_W + 1);

  // LCD byte constants
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] ROW2_OFFSET   = 8'h40;
  localparam logic [7:0] CHR_ZERO      = 8'h30;
  localparam logic [7:0] CHR_X         = 8'h78;
  localparam logic [7:0] CHR_PLUS      = 8'h2B;
  localparam logic [7:0] CHR_MINUS     = 8'h2D;
  localparam logic [7:0] CHR_UPPER_A   = 8'h41;
  localparam logic [7:0] CMD_FUNC_SET  = 8'h38;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;

  // Request word
  typedef struct packed {
    logic [2:0]  func;
    logic [1:0]  line;
    logic [5:0]  column;
    logic [15:0] value;
    logic [3:0]  digit_count;
  } lcdnf_req_t;

  // Result word
  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } lcdnf_rsp_t;

  // Uppercase ASCII hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = CHR_ZERO + {4'd0, nib};
    end else begin
      r = CHR_UPPER_A + {4'd0, nib} - 8'd10;
    end
    return r;
  endfunction

  // Four-command controller setup sequence
  function automatic logic [7:0] init_cmd(input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0: r = CMD_FUNC_SET;
      2'd1: r = CMD_DISP_ON;
      2'd2: r = CMD_ENTRY;
      2'd3: r = CMD_CLEAR;
      default: r = CMD_CLEAR;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/lcdnf_bcd.sv */
// Iterative binary to BCD converter (shift and add-3), one bit per cycle.
// Depends on lcdnf_pkg for widths.
module lcdnf_bcd (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      load,
  input  logic [lcdnf_pkg::BIN_W-1:0]               bin,
  output logic                                      done,
  output logic [lcdnf_pkg::BCD_DIGITS-1:0][3:0]     bcd
);
  import lcdnf_pkg::*;

  logic [BIN_W-1:0]            bin_sr;
  logic [BCD_DIGITS-1:0][3:0]  bcd_adj;
  logic [ITER_W-1:0]           iter;

  // Add-3 correction on every nibble before the shift
  always_comb begin
    for (int d = 0; d < BCD_DIGITS; d++) begin
      bcd_adj[d] = (bcd[d] >= 4'd5) ? bcd[d] + 4'd3 : bcd[d];
    end
  end

  // Shift register and iteration count
  always_ff @(posedge clk) begin
    if (rst) begin
      iter <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (load) begin
        bin_sr <= bin;
        bcd    <= '0;
        iter   <= ITER_W'(BIN_W);
      end else if (iter != '0) begin
        {bcd, bin_sr} <= {bcd_adj[BCD_DIGITS-1:0], bin_sr} << 1;
        iter          <= iter - 1'b1;
        done          <= (iter == ITER_W'(1));
      end
    end
  end

  // Converter checks
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("bcd done held longer than one cycle");
  a_done_end: assert property (@(posedge clk) disable iff (rst)
    done |-> iter == '0)
    else $error("bcd done while iterations remain");
  a_load_count: assert property (@(posedge clk) disable iff (rst)
    load |=> iter == ITER_W'(BIN_W))
    else $error("bcd iteration count not loaded");

endmodule

/* hw/rtl/lcd_number_display_formatter.sv */
// Top level of the LCD number display formatter: request sequencer and byte emitter.
// Depends on lcdnf_pkg and lcdnf_bcd.
//
// A request is taken when start is high and busy is low; busy then stays high
// until its last byte has been issued. Bytes come out one per cycle on result,
// each marked by strobe for exactly one cycle, and the final byte of a request
// carries last; the receiver must take every byte as it appears. Decimal modes
// first run the magnitude through a bit-serial binary to BCD converter, one bit
// per cycle, and the sequencer leaves conversion once the registered done of
// the converter reaches it. A request produces 0 to 12 bytes; one that
// produces no byte never raises busy.
module lcd_number_display_formatter (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  lcdnf_pkg::lcdnf_req_t  req,
  output logic                   busy,
  output logic                   strobe,
  output lcdnf_pkg::lcdnf_rsp_t  result
);
  import lcdnf_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_EMIT} state_t;

  state_t                     state;
  lcdnf_req_t                 req_q;
  logic [3:0]                 cnt;        // saturated digit count
  logic                       cur_pend;
  logic                       sign_pend;
  logic [3:0]                 j;          // body byte index
  logic [3:0]                 rem;        // bytes left to issue

  logic                       conv_load;
  logic                       conv_done;
  logic [BCD_DIGITS-1:0][3:0] bcd;
  logic [BIN_W-1:0]           mag;

  logic [3:0]                 cnt_in;
  logic                       has_cur;
  logic                       has_sign;
  logic [3:0]                 body_n;
  logic [3:0]                 total;
  logic                       is_dec;

  logic [7:0]                 col_off;
  logic [7:0]                 cur_byte;
  logic [3:0]                 pos;
  logic [3:0]                 digit;
  lcdnf_rsp_t                 word_next;

  // Request decode
  always_comb begin
    cnt_in   = (req.digit_count > MAX_DIGITS) ? MAX_DIGITS : req.digit_count;
    is_dec   = (req.func == FUNC_UDEC) || (req.func == FUNC_SDEC);
    has_cur  = (req.func <= FUNC_CHAR) && ((req.line == LINE_TOP) || (req.line == LINE_BOT));
    has_sign = (req.func == FUNC_SDEC) && (req.value != 16'd0);
    unique case (req.func)
      FUNC_UDEC, FUNC_SDEC: body_n = cnt_in;
      FUNC_HEX:             body_n = 4'd4;
      FUNC_CHAR:            body_n = 4'd1;
      FUNC_INIT:            body_n = 4'd4;
      default:              body_n = 4'd0;
    endcase
    total = body_n + {3'd0, has_cur} + {3'd0, has_sign};
    if ((req.func == FUNC_SDEC) && req.value[15]) begin
      mag = BIN_W'(17'h10000 - {1'b0, req.value});
    end else begin
      mag = {1'b0, req.value};
    end
  end

  assign conv_load = (state == S_IDLE) && start && is_dec && (total != 4'd0);
  assign busy      = (state != S_IDLE);

  lcdnf_bcd u_bcd (
    .clk  (clk),
    .rst  (rst),
    .load (conv_load),
    .bin  (mag),
    .done (conv_done),
    .bcd  (bcd)
  );

  // Byte selection for the current emit step
  always_comb begin
    col_off  = {2'd0, req_q.column} - 8'd1;
    cur_byte = (req_q.line == LINE_BOT) ? (CMD_SET_DDRAM | (col_off + ROW2_OFFSET))
                                        : (CMD_SET_DDRAM | col_off);
    pos      = cnt - 4'd1 - j;
    digit    = (pos < 4'(BCD_DIGITS)) ? bcd[pos[POS_W-1:0]] : 4'd0;
    word_next.last = (rem == 4'd1);
    if (cur_pend) begin
      word_next.is_data  = 1'b0;
      word_next.bus_byte = cur_byte;
    end else if (sign_pend) begin
      word_next.is_data  = 1'b1;
      word_next.bus_byte = req_q.value[15] ? CHR_MINUS : CHR_PLUS;
    end else begin
      word_next.is_data = 1'b1;
      unique case (req_q.func)
        FUNC_UDEC, FUNC_SDEC: word_next.bus_byte = CHR_ZERO + {4'd0, digit};
        FUNC_HEX: begin
          unique case (j[1:0])
            2'd0:    word_next.bus_byte = CHR_ZERO;
            2'd1:    word_next.bus_byte = CHR_X;
            2'd2:    word_next.bus_byte = hex_char(req_q.value[7:4]);
            default: word_next.bus_byte = hex_char(req_q.value[3:0]);
          endcase
        end
        FUNC_CHAR: word_next.bus_byte = req_q.value[7:0];
        FUNC_INIT: begin
          word_next.is_data  = 1'b0;
          word_next.bus_byte = init_cmd(j[1:0]);
        end
        default: word_next.bus_byte = 8'd0;
      endcase
    end
  end

  // Sequencer and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
      rem    <= 4'd0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req_q     <= req;
            cnt       <= cnt_in;
            cur_pend  <= has_cur;
            sign_pend <= has_sign;
            j         <= 4'd0;
            rem       <= total;
            if (total != 4'd0) begin
              state <= is_dec ? S_CONV : S_EMIT;
            end
          end
        end
        S_CONV: begin
          if (conv_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          strobe <= 1'b1;
          result <= word_next;
          rem    <= rem - 4'd1;
          if (cur_pend) begin
            cur_pend <= 1'b0;
          end else if (sign_pend) begin
            sign_pend <= 1'b0;
          end else begin
            j <= j + 4'd1;
          end
          if (rem == 4'd1) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Sequencer checks
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last) |=> !strobe)
    else $error("word issued right after a last word");
  a_emit_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (rem != 4'd0))
    else $error("emit with no bytes left");
  a_conv_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CONV) |=> !strobe)
    else $error("word issued during conversion");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last) |-> (state == S_IDLE))
    else $error("last word issued while still emitting");

endmodule
